[rtl/nrt_pkg.sv]
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared widths, constants and types for the Newton n-th root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nrt_pkg;

    // Algorithm constants
    localparam int FRAC_BITS      = 16;
    localparam int MAX_INDEX      = 8;
    localparam int MAX_ITERATIONS = 64;

    // Field widths
    localparam int RAD_W  = 32;
    localparam int IDX_W  = 4;
    localparam int TOL_W  = 16;
    localparam int ROOT_W = 32;
    localparam int STAT_W = 2;
    localparam int ITER_W = 7;

    // Datapath widths
    localparam int POW_W  = 62;                 // saturated powers and divisor
    localparam int MUL_W  = 32;                 // shared multiplier operand width
    localparam int PROD_W = 3 * MUL_W;          // full power times estimate product
    localparam int QUOT_W = 34;                 // step quotient, cap included
    localparam int NUM_W  = POW_W + FRAC_BITS;  // shifted dividend
    localparam int DCNT_W = $clog2(NUM_W);

    // Saturation points and fixed-point one
    localparam logic [POW_W-1:0]  SAT_WIDE  = '1;
    localparam logic [QUOT_W-1:0] QUOT_CAP  = QUOT_W'(1) << (QUOT_W - 1);
    localparam logic [ROOT_W-1:0] ROOT_MAX  = '1;
    localparam logic [ROOT_W-1:0] ONE_X     = ROOT_W'(1) << FRAC_BITS;
    localparam logic [POW_W-1:0]  ONE_P     = POW_W'(1) << FRAC_BITS;
    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_CONVERGED = 2'd0,
        ST_ITER_CAP  = 2'd1,
        ST_ZERO_DIV  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_DEN,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

[rtl/nrt_in_if.sv]
// ----------------------------------------------------------------------------
// nrt_in_if
// Input channel: radicand and root index with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrt_in_if;
    import nrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [RAD_W-1:0]   radicand;
    logic [IDX_W-1:0]   root_index;

    modport source (output valid, output radicand, output root_index, input ready);
    modport sink   (input valid, input radicand, input root_index, output ready);
endinterface

`default_nettype wire

[rtl/nrt_out_if.sv]
// ----------------------------------------------------------------------------
// nrt_out_if
// Result channel: root, status and step count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrt_out_if;
    import nrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [ROOT_W-1:0]  root;
    logic [STAT_W-1:0]  status;
    logic [ITER_W-1:0]  iterations_used;

    modport source (output valid, output root, output status, output iterations_used,
                    input ready);
    modport sink   (input valid, input root, input status, input iterations_used,
                    output ready);
endinterface

`default_nettype wire

[rtl/nrt_cfg_if.sv]
// ----------------------------------------------------------------------------
// nrt_cfg_if
// Configuration write channel: tolerance value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrt_cfg_if;
    import nrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOL_W-1:0]   tolerance;

    modport source (output valid, output tolerance, input ready);
    modport sink   (input valid, input tolerance, output ready);
endinterface

`default_nettype wire

[rtl/nrt_mul.sv]
// ----------------------------------------------------------------------------
// nrt_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_mul (
    input  logic                            i_clk,
    input  logic [nrt_pkg::MUL_W-1:0]       i_a,
    input  logic [nrt_pkg::MUL_W-1:0]       i_b,
    output logic [2*nrt_pkg::MUL_W-1:0]     o_p
);
    import nrt_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    // One partial product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[rtl/nrt_div.sv]
// ----------------------------------------------------------------------------
// nrt_div
// Radix-2 restoring divider: floor(mag * 2^FRAC_BITS / den), capped at 2^33.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [nrt_pkg::POW_W-1:0]       i_mag,
    input  logic [nrt_pkg::POW_W-1:0]       i_den,
    output logic                            o_done,
    output logic [nrt_pkg::QUOT_W-1:0]      o_quot
);
    import nrt_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [POW_W-1:0]   r_rem, n_rem;
    logic [POW_W-1:0]   r_den, n_den;
    logic [QUOT_W-1:0]  r_q, n_q;
    logic               r_ovf, n_ovf;

    logic [POW_W:0]     trial;
    logic [POW_W:0]     trial_sub;
    logic               ge;

    // Trial subtract for one quotient bit
    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign ge        = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = {i_mag, FRAC_BITS'(0)};
            n_rem  = '0;
            n_den  = i_den;
            n_q    = '0;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            n_rem = ge ? trial_sub[POW_W-1:0] : trial[POW_W-1:0];
            n_num = r_num << 1;
            n_q   = {r_q[QUOT_W-2:0], ge};
            // a bit leaving the top means the quotient is past the cap
            n_ovf = r_ovf | r_q[QUOT_W-1];
            n_cnt = r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || (r_q > QUOT_CAP)) ? QUOT_CAP : r_q;

endmodule

`default_nettype wire

[rtl/newton_nth_root_unit.sv]
// ----------------------------------------------------------------------------
// newton_nth_root_unit
// Newton-Raphson n-th root of an unsigned Q16.16 radicand.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : radicand (Q16.16) and root_index (2..8, clamped) per item.
//   o_out  : root (Q16.16), status (converged / cap reached / zero divisor)
//            and the number of Newton steps used.
//   i_cfg  : tolerance write, always ready; write only while the unit idles.
// The unit takes one item at a time; i_in.ready is high only while idle.
// Each Newton step runs a convergence check, then, for each power, two
// partial products and an accumulate on the shared 32x32 multiplier,
// then a divisor step and the bit-serial divider (78 quotient bits plus
// the done flag). An item runs up to 64 Newton steps before its result
// is passed to the output register.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// unit holds that result and stays busy until the register frees up.
// Reset (synchronous, active low) sets tolerance to 1 and empties the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_nth_root_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrt_in_if.sink      i_in,
    nrt_out_if.source   o_out,
    nrt_cfg_if.sink     i_cfg
);
    import nrt_pkg::*;

    t_state             r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [RAD_W-1:0]   r_rad, n_rad;
    logic [IDX_W-1:0]   r_n, n_n;
    logic [ROOT_W-1:0]  r_x, n_x;
    logic [ROOT_W-1:0]  r_xp, n_xp;
    logic [ITER_W-1:0]  r_iters, n_iters;
    t_status            r_status, n_status;
    logic [POW_W-1:0]   r_pow, n_pow;
    logic [POW_W-1:0]   r_pm, n_pm;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [2*MUL_W-1:0] r_lo_pp, n_lo_pp;
    logic               r_up, n_up;

    logic               r_out_valid;
    logic [ROOT_W-1:0]  r_out_root;
    t_status            r_out_status;
    logic [ITER_W-1:0]  r_out_iters;
    logic               out_load;

    logic [MUL_W-1:0]       mul_a;
    logic [2*MUL_W-1:0]     mul_p;
    logic [PROD_W-1:0]      prod;
    logic [POW_W-1:0]       mul_res;
    logic [IDX_W-1:0]       cnt_inc;
    logic [ROOT_W-1:0]      x_diff;
    logic [POW_W+IDX_W-1:0] den_full;
    logic [POW_W-1:0]       den_c;
    logic [POW_W-1:0]       rad_w;
    logic                   up_c;
    logic [POW_W-1:0]       mag_c;
    logic                   div_start;
    logic                   div_done;
    logic [QUOT_W-1:0]      div_quot;
    logic [QUOT_W:0]        sum_c;
    logic [ROOT_W-1:0]      x_new;
    logic [IDX_W-1:0]       idx_clamped;

    // Shared multiplier: power times estimate, two halves of the power
    nrt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_x),
        .o_p   (mul_p)
    );

    // Bit-serial divider for the step quotient
    nrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag_c),
        .i_den   (den_c),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Index clamp to 2..MAX_INDEX
    always_comb begin
        if (i_in.root_index < IDX_W'(2)) begin
            idx_clamped = IDX_W'(2);
        end else if (i_in.root_index > IDX_W'(MAX_INDEX)) begin
            idx_clamped = IDX_W'(MAX_INDEX);
        end else begin
            idx_clamped = i_in.root_index;
        end
    end

    // Change since the previous estimate
    assign x_diff = (r_x > r_xp) ? (r_x - r_xp) : (r_xp - r_x);

    // Full product from the two partial products, then saturate
    assign prod    = {mul_p, MUL_W'(0)} + PROD_W'(r_lo_pp);
    assign mul_res = (|prod[PROD_W-1:2*MUL_W]) ? SAT_WIDE
                                               : POW_W'(prod[2*MUL_W-1:FRAC_BITS]);
    assign cnt_inc = r_cnt + IDX_W'(1);

    // Divisor n * x^(n-1), saturated; residual magnitude and sign
    assign den_full = (POW_W+IDX_W)'(r_pm) * (POW_W+IDX_W)'(r_n);
    assign den_c    = (den_full > (POW_W+IDX_W)'(SAT_WIDE)) ? SAT_WIDE
                                                             : den_full[POW_W-1:0];
    assign rad_w    = POW_W'(r_rad);
    assign up_c     = (rad_w >= r_pow);
    assign mag_c    = up_c ? (rad_w - r_pow) : (r_pow - rad_w);

    // Estimate update, saturating high and clamping at zero
    assign sum_c = (QUOT_W+1)'(r_x) + (QUOT_W+1)'(div_quot);
    always_comb begin
        if (r_up) begin
            x_new = (sum_c > (QUOT_W+1)'(ROOT_MAX)) ? ROOT_MAX : sum_c[ROOT_W-1:0];
        end else begin
            x_new = (div_quot > QUOT_W'(r_x)) ? '0 : (r_x - div_quot[ROOT_W-1:0]);
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_rad     = r_rad;
        n_n       = r_n;
        n_x       = r_x;
        n_xp      = r_xp;
        n_iters   = r_iters;
        n_status  = r_status;
        n_pow     = r_pow;
        n_pm      = r_pm;
        n_cnt     = r_cnt;
        n_lo_pp   = r_lo_pp;
        n_up      = r_up;
        mul_a     = r_pow[MUL_W-1:0];
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rad   = i_in.radicand;
                    n_n     = idx_clamped;
                    n_x     = ONE_X;
                    n_xp    = '0;
                    n_iters = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (x_diff < ROOT_W'(r_tol)) begin
                    n_status = ST_CONVERGED;
                    n_state  = S_FINISH;
                end else if (r_iters >= ITER_W'(MAX_ITERATIONS)) begin
                    n_status = ST_ITER_CAP;
                    n_state  = S_FINISH;
                end else begin
                    n_pow   = ONE_P;
                    n_cnt   = '0;
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                mul_a   = r_pow[MUL_W-1:0];
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_a   = MUL_W'(r_pow[POW_W-1:MUL_W]);
                n_lo_pp = mul_p;
                n_state = S_MUL_SUM;
            end
            S_MUL_SUM: begin
                n_pow = mul_res;
                n_cnt = cnt_inc;
                // keep x^(n-1) for the divisor
                if (cnt_inc == r_n - IDX_W'(1)) begin
                    n_pm = mul_res;
                end
                n_state = (cnt_inc == r_n) ? S_DEN : S_MUL_LO;
            end
            S_DEN: begin
                if (den_c == '0) begin
                    n_status = ST_ZERO_DIV;
                    n_state  = S_FINISH;
                end else begin
                    n_up      = up_c;
                    div_start = 1'b1;
                    n_state   = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_xp    = r_x;
                    n_x     = x_new;
                    n_iters = r_iters + ITER_W'(1);
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_tol <= i_cfg.tolerance;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rad    <= n_rad;
        r_n      <= n_n;
        r_x      <= n_x;
        r_xp     <= n_xp;
        r_iters  <= n_iters;
        r_status <= n_status;
        r_pow    <= n_pow;
        r_pm     <= n_pm;
        r_cnt    <= n_cnt;
        r_lo_pp  <= n_lo_pp;
        r_up     <= n_up;
        if (out_load) begin
            r_out_root   <= r_x;
            r_out_status <= r_status;
            r_out_iters  <= r_iters;
        end
    end

    // Ports
    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.root            = r_out_root;
    assign o_out.status          = r_out_status;
    assign o_out.iterations_used = r_out_iters;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHECK))
        else $error("accepted item did not start the convergence check");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.iterations_used <= ITER_W'(MAX_ITERATIONS)))
        else $error("step count above the cap");

    a_cap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_ITER_CAP))
            |-> (o_out.iterations_used == ITER_W'(MAX_ITERATIONS)))
        else $error("cap status with a short step count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten while occupied");

endmodule

`default_nettype wire
